// File: rtl/nearest_point_match_assert.svh
// ----------------------------------------------------------------------------
// nearest_point_match_assert
// Assertion macros shared by the nearest point match RTL.
// ----------------------------------------------------------------------------
// Each macro expands to one labeled concurrent assertion that is
// clocked on clk and disabled while rst_n is low.
`ifndef NEAREST_POINT_MATCH_ASSERT_SVH
`define NEAREST_POINT_MATCH_ASSERT_SVH

// Same-cycle implication.
`define NPM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest_point_match assertion failed");

// Next-cycle implication.
`define NPM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest_point_match assertion failed");

`endif

// File: rtl/npm_pkg.sv
// ----------------------------------------------------------------------------
// npm_pkg
// Shared constants, codes and types of the nearest point match block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npm_pkg;

    localparam int MAX_REF_POINTS = 1024;
    localparam int COORD_BITS     = 16;
    localparam int IDX_BITS       = $clog2(MAX_REF_POINTS);
    localparam int CNT_BITS       = $clog2(MAX_REF_POINTS + 1);
    localparam int DIST_BITS      = 2 * COORD_BITS + 1;
    localparam int RAM_WIDTH      = 2 * COORD_BITS;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // One store read issued by the scan controller.
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [IDX_BITS-1:0] index;
    } scan_req_t;

    // One scored reference point leaving the distance pipeline.
    typedef struct packed {
        logic                         valid;
        logic                         last;
        logic [IDX_BITS-1:0]          index;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [DIST_BITS-1:0]         dist_sq;
    } dist_res_t;

endpackage

`default_nettype wire

// File: rtl/nearest_point_match.sv
// ----------------------------------------------------------------------------
// nearest_point_match
// Brute-force 2-D nearest-neighbor search over a loaded set of points.
// ----------------------------------------------------------------------------
// The input channel (in_valid / in_ready) carries one request per
// transaction: a load (req_type 0) appends point_x / point_y to the store,
// and new_set on a load empties the store and clears the drop flag first.
// Loads beyond 1024 points are dropped and reported by set_overflowed.
// A query (req_type 1) returns one transaction on the output channel
// (out_valid / out_ready): the closest stored point, its index and its
// squared distance; the earliest point wins a tie, and an empty store
// gives found = 0 with zero result fields.
// Loads may follow back to back. A query on N > 0 stored points scans them
// in order: the scan reads one point per cycle from the single read port of
// the point store, which feeds a three-stage distance pipeline. An empty
// store skips the scan. No new request is taken until the query's result is
// in the output register; loads are accepted while it waits there, and a
// following query scans but holds its result until the receiver takes the
// earlier one. Reset empties the store and the flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_match (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   req_type,
    input  wire logic                                   new_set,
    input  wire logic signed [npm_pkg::COORD_BITS-1:0]  point_x,
    input  wire logic signed [npm_pkg::COORD_BITS-1:0]  point_y,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        found,
    output logic signed [npm_pkg::COORD_BITS-1:0]       match_x,
    output logic signed [npm_pkg::COORD_BITS-1:0]       match_y,
    output logic [npm_pkg::IDX_BITS-1:0]                match_index,
    output logic [npm_pkg::DIST_BITS-1:0]               min_sq_dist,
    output logic                                        set_overflowed
);

    import npm_pkg::*;

    logic                         wr_en;
    logic [IDX_BITS-1:0]          wr_addr;
    logic [RAM_WIDTH-1:0]         wr_data;
    logic [RAM_WIDTH-1:0]         rdata;
    scan_req_t                    req;
    dist_res_t                    res;
    logic signed [COORD_BITS-1:0] qx;
    logic signed [COORD_BITS-1:0] qy;

    npm_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .new_set        (new_set),
        .point_x        (point_x),
        .point_y        (point_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_x        (match_x),
        .match_y        (match_y),
        .match_index    (match_index),
        .min_sq_dist    (min_sq_dist),
        .set_overflowed (set_overflowed),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .req            (req),
        .qx             (qx),
        .qy             (qy),
        .res            (res)
    );

    npm_ram #(
        .WIDTH (RAM_WIDTH),
        .DEPTH (MAX_REF_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (req.valid),
        .raddr (req.index),
        .rdata (rdata)
    );

    npm_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (rdata),
        .qx    (qx),
        .qy    (qy),
        .res   (res)
    );

endmodule

`default_nettype wire

// File: rtl/npm_ram.sv
// ----------------------------------------------------------------------------
// npm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/npm_dist.sv
// ----------------------------------------------------------------------------
// npm_dist
// Pipelined squared-distance unit: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npm_dist (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire npm_pkg::scan_req_t                     req,
    input  wire logic [npm_pkg::RAM_WIDTH-1:0]          rdata,
    input  wire logic signed [npm_pkg::COORD_BITS-1:0]  qx,
    input  wire logic signed [npm_pkg::COORD_BITS-1:0]  qy,
    output npm_pkg::dist_res_t                          res
);

    import npm_pkg::*;

    scan_req_t                    req0_reg;
    scan_req_t                    req1_reg;
    scan_req_t                    req2_reg;
    logic signed [COORD_BITS-1:0] x1_reg;
    logic signed [COORD_BITS-1:0] y1_reg;
    logic signed [COORD_BITS-1:0] x2_reg;
    logic signed [COORD_BITS-1:0] y2_reg;
    logic [COORD_BITS-1:0]        adx_reg;
    logic [COORD_BITS-1:0]        ady_reg;
    logic [2*COORD_BITS-1:0]      sqx_reg;
    logic [2*COORD_BITS-1:0]      sqy_reg;
    dist_res_t                    res_reg;

    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]          adx_full;
    logic [COORD_BITS:0]          ady_full;

    always_comb
    begin
        rx = rdata[RAM_WIDTH-1:COORD_BITS];
        ry = rdata[COORD_BITS-1:0];
        dx = $signed({rx[COORD_BITS-1], rx}) - $signed({qx[COORD_BITS-1], qx});
        dy = $signed({ry[COORD_BITS-1], ry}) - $signed({qy[COORD_BITS-1], qy});
        // The magnitude of a difference of two coordinates always fits
        // in COORD_BITS unsigned bits.
        adx_full = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
        ady_full = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req0_reg <= '0;
            req1_reg <= '0;
            req2_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            req0_reg <= req;
            req1_reg <= req0_reg;
            req2_reg <= req1_reg;
            res_reg.valid   <= req2_reg.valid;
            res_reg.last    <= req2_reg.last;
            res_reg.index   <= req2_reg.index;
            res_reg.x       <= x2_reg;
            res_reg.y       <= y2_reg;
            res_reg.dist_sq <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= rx;
        y1_reg  <= ry;
        adx_reg <= adx_full[COORD_BITS-1:0];
        ady_reg <= ady_full[COORD_BITS-1:0];
        x2_reg  <= x1_reg;
        y2_reg  <= y1_reg;
        sqx_reg <= adx_reg * adx_reg;
        sqy_reg <= ady_reg * ady_reg;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: rtl/npm_scan.sv
// ----------------------------------------------------------------------------
// npm_scan
// Request handling, store fill control, scan sequencing and best-match
// tracking, with the result register toward the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_point_match_assert.svh"

module npm_scan (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   req_type,
    input  wire logic                                   new_set,
    input  wire logic signed [npm_pkg::COORD_BITS-1:0]  point_x,
    input  wire logic signed [npm_pkg::COORD_BITS-1:0]  point_y,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        found,
    output logic signed [npm_pkg::COORD_BITS-1:0]       match_x,
    output logic signed [npm_pkg::COORD_BITS-1:0]       match_y,
    output logic [npm_pkg::IDX_BITS-1:0]                match_index,
    output logic [npm_pkg::DIST_BITS-1:0]               min_sq_dist,
    output logic                                        set_overflowed,
    output logic                                        wr_en,
    output logic [npm_pkg::IDX_BITS-1:0]                wr_addr,
    output logic [npm_pkg::RAM_WIDTH-1:0]               wr_data,
    output npm_pkg::scan_req_t                          req,
    output logic signed [npm_pkg::COORD_BITS-1:0]       qx,
    output logic signed [npm_pkg::COORD_BITS-1:0]       qy,
    input  wire npm_pkg::dist_res_t                     res
);

    import npm_pkg::*;

    localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_REF_POINTS);

    state_t                       state_reg, state_next;
    logic [CNT_BITS-1:0]          count_reg, count_next;
    logic                         overflow_reg, overflow_next;
    logic [CNT_BITS-1:0]          rd_cnt_reg, rd_cnt_next;
    logic signed [COORD_BITS-1:0] qx_reg, qx_next;
    logic signed [COORD_BITS-1:0] qy_reg, qy_next;
    logic                         have_best_reg, have_best_next;
    logic signed [COORD_BITS-1:0] best_x_reg, best_x_next;
    logic signed [COORD_BITS-1:0] best_y_reg, best_y_next;
    logic [IDX_BITS-1:0]          best_idx_reg, best_idx_next;
    logic [DIST_BITS-1:0]         best_dist_reg, best_dist_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         found_reg, found_next;
    logic signed [COORD_BITS-1:0] mx_reg, mx_next;
    logic signed [COORD_BITS-1:0] my_reg, my_next;
    logic [IDX_BITS-1:0]          midx_reg, midx_next;
    logic [DIST_BITS-1:0]         mdist_reg, mdist_next;
    logic                         movf_reg, movf_next;

    logic accept;
    logic take;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        rd_cnt_next    = rd_cnt_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        have_best_next = have_best_reg;
        best_x_next    = best_x_reg;
        best_y_next    = best_y_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        midx_next      = midx_reg;
        mdist_next     = mdist_reg;
        movf_next      = movf_reg;

        in_ready = (state_reg == ST_IDLE);
        accept   = in_valid && in_ready;
        wr_en    = 1'b0;
        wr_addr  = count_reg[IDX_BITS-1:0];
        wr_data  = {point_x, point_y};
        req      = '0;

        // Strictly smaller wins, so on a tie the earliest point stays.
        take = res.valid && (!have_best_reg || (res.dist_sq < best_dist_reg));
        if (take)
        begin
            have_best_next = 1'b1;
            best_x_next    = res.x;
            best_y_next    = res.y;
            best_idx_next  = res.index;
            best_dist_next = res.dist_sq;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        if (new_set)
                        begin
                            overflow_next = 1'b0;
                            wr_en         = 1'b1;
                            wr_addr       = '0;
                            count_next    = CNT_BITS'(1);
                        end
                        else if (count_reg < MAX_COUNT)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_BITS'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    else
                    begin
                        qx_next        = point_x;
                        qy_next        = point_y;
                        have_best_next = 1'b0;
                        best_x_next    = '0;
                        best_y_next    = '0;
                        best_idx_next  = '0;
                        best_dist_next = '0;
                        rd_cnt_next    = '0;
                        state_next     = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                req.valid   = 1'b1;
                req.index   = rd_cnt_reg[IDX_BITS-1:0];
                req.last    = (rd_cnt_reg == count_reg - CNT_BITS'(1));
                rd_cnt_next = rd_cnt_reg + CNT_BITS'(1);
                if (req.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (res.valid && res.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = have_best_reg;
                    mx_next        = best_x_reg;
                    my_next        = best_y_reg;
                    midx_next      = best_idx_reg;
                    mdist_next     = best_dist_reg;
                    movf_next      = overflow_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            rd_cnt_reg    <= '0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            rd_cnt_reg    <= rd_cnt_next;
            have_best_reg <= have_best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        best_x_reg    <= best_x_next;
        best_y_reg    <= best_y_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        found_reg     <= found_next;
        mx_reg        <= mx_next;
        my_reg        <= my_next;
        midx_reg      <= midx_next;
        mdist_reg     <= mdist_next;
        movf_reg      <= movf_next;
    end

    assign qx             = qx_reg;
    assign qy             = qy_reg;
    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign match_x        = mx_reg;
    assign match_y        = my_reg;
    assign match_index    = midx_reg;
    assign min_sq_dist    = mdist_reg;
    assign set_overflowed = movf_reg;

    `NPM_ASSERT_IMP(a_count_in_range, 1'b1, count_reg <= MAX_COUNT)
    `NPM_ASSERT_IMP(a_result_only_in_scan, res.valid,
                    (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
    `NPM_ASSERT_NXT(a_query_starts_scan,
                    accept && (req_type == REQ_QUERY) && (count_reg != '0),
                    state_reg == ST_SCAN)
    `NPM_ASSERT_NXT(a_full_load_sets_overflow,
                    accept && (req_type == REQ_LOAD) && !new_set && (count_reg == MAX_COUNT),
                    overflow_reg && (count_reg == MAX_COUNT))

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the nearest point match block.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first. It covers the empty store
// after reset, coordinate extremes, distance ties and new_set on a query.
// Random point sets follow, each with queries aimed near, on and away from
// the stored points. A scoreboard model of the point store predicts the
// query results that no directed row gives itself, and each result
// transaction is checked field by field against the oldest pending
// prediction. Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import npm_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int N_DIRECTED      = 22;

    typedef struct packed {
        logic                         found;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [IDX_BITS-1:0]          index;
        logic [DIST_BITS-1:0]         dist_sq;
        logic                         ovf;
    } match_t;

    typedef struct {
        logic   req;
        logic   ns;
        int     x;
        int     y;
        bit     typed;
        match_t want;
    } stim_row_t;

    localparam match_t NO_MATCH = '0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic req_type = 1'b0;
    logic new_set = 1'b0;
    logic signed [COORD_BITS-1:0] point_x = '0;
    logic signed [COORD_BITS-1:0] point_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic found;
    logic signed [COORD_BITS-1:0] match_x;
    logic signed [COORD_BITS-1:0] match_y;
    logic [IDX_BITS-1:0] match_index;
    logic [DIST_BITS-1:0] min_sq_dist;
    logic set_overflowed;

    // Scoreboard copy of the point store.
    logic signed [COORD_BITS-1:0] point_store_x [MAX_REF_POINTS];
    logic signed [COORD_BITS-1:0] point_store_y [MAX_REF_POINTS];
    int n_stored = 0;
    bit drop_flag = 1'b0;

    match_t pending_matches [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int loads_sent = 0;
    int loads_dropped = 0;
    int queries_sent = 0;
    int tie_queries = 0;
    int results_checked = 0;
    int mismatches = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{REQ_QUERY, 1'b0, 0, 0, 1'b1, '{1'b0, 0, 0, 0, 33'd0, 1'b0}},
        '{REQ_LOAD, 1'b1, -32768, -32768, 1'b0, NO_MATCH},
        '{REQ_QUERY, 1'b0, 32767, 32767, 1'b1,
          '{1'b1, -32768, -32768, 0, 33'd8589672450, 1'b0}},
        '{REQ_QUERY, 1'b0, -32768, -32768, 1'b1,
          '{1'b1, -32768, -32768, 0, 33'd0, 1'b0}},
        '{REQ_LOAD, 1'b0, 32767, 32767, 1'b0, NO_MATCH},
        '{REQ_QUERY, 1'b0, 32767, 32767, 1'b1,
          '{1'b1, 32767, 32767, 1, 33'd0, 1'b0}},
        '{REQ_QUERY, 1'b0, 0, 0, 1'b0, NO_MATCH},
        '{REQ_QUERY, 1'b0, -1, -1, 1'b0, NO_MATCH},
        // Four points at the same distance from the origin.
        '{REQ_LOAD, 1'b1, 10, 0, 1'b0, NO_MATCH},
        '{REQ_LOAD, 1'b0, -10, 0, 1'b0, NO_MATCH},
        '{REQ_LOAD, 1'b0, 0, 10, 1'b0, NO_MATCH},
        '{REQ_LOAD, 1'b0, 0, -10, 1'b0, NO_MATCH},
        '{REQ_QUERY, 1'b0, 0, 0, 1'b1, '{1'b1, 10, 0, 0, 33'd100, 1'b0}},
        '{REQ_QUERY, 1'b1, 0, 0, 1'b1, '{1'b1, 10, 0, 0, 33'd100, 1'b0}},
        '{REQ_QUERY, 1'b0, 0, 5, 1'b0, NO_MATCH},
        '{REQ_LOAD, 1'b0, 0, 10, 1'b0, NO_MATCH},
        '{REQ_QUERY, 1'b0, 0, 9, 1'b0, NO_MATCH},
        '{REQ_LOAD, 1'b1, 32767, -32768, 1'b0, NO_MATCH},
        '{REQ_QUERY, 1'b0, -32768, 32767, 1'b1,
          '{1'b1, 32767, -32768, 0, 33'd8589672450, 1'b0}},
        '{REQ_QUERY, 1'b0, 0, -32768, 1'b0, NO_MATCH},
        '{REQ_LOAD, 1'b0, -32768, 32767, 1'b0, NO_MATCH},
        '{REQ_QUERY, 1'b0, -32768, -32768, 1'b0, NO_MATCH}
    };

    nearest_point_match DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .new_set        (new_set),
        .point_x        (point_x),
        .point_y        (point_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_x        (match_x),
        .match_y        (match_y),
        .match_index    (match_index),
        .min_sq_dist    (min_sq_dist),
        .set_overflowed (set_overflowed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** nearest_point_match: FAILED **");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready = !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1, 2, 3: return 16'($urandom_range(0, 200)) - 16'sd100;
            default: return 16'($urandom);
        endcase
    endfunction

    // Query points land on, near or away from the stored points.
    task automatic aim_query(output logic signed [COORD_BITS-1:0] ax,
                             output logic signed [COORD_BITS-1:0] ay);
        int i;
        i = $urandom_range(0, n_stored - 1);
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                ax = point_store_x[i] + 16'($urandom_range(0, 6)) - 16'sd3;
                ay = point_store_y[i] + 16'($urandom_range(0, 6)) - 16'sd3;
            end
            3:
            begin
                ax = point_store_x[i];
                ay = point_store_y[i];
            end
            4:
            begin
                ax = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                ay = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            default:
            begin
                ax = rand_coord();
                ay = rand_coord();
            end
        endcase
    endtask

    // Drives one request transaction and, once it is accepted, updates the
    // point store copy or queues the predicted match.
    task automatic send_request(input logic req, input logic ns,
                                input logic signed [COORD_BITS-1:0] x,
                                input logic signed [COORD_BITS-1:0] y,
                                input bit typed, input match_t want);
        match_t pred;
        longint dx;
        longint dy;
        longint unsigned d;
        longint unsigned best_d;
        int best;
        bit tie;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = req;
        new_set = ns;
        point_x = x;
        point_y = y;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (req == REQ_LOAD)
        begin
            loads_sent++;
            if (ns)
            begin
                n_stored = 0;
                drop_flag = 1'b0;
            end
            if (n_stored < MAX_REF_POINTS)
            begin
                point_store_x[n_stored] = x;
                point_store_y[n_stored] = y;
                n_stored++;
            end
            else
            begin
                drop_flag = 1'b1;
                loads_dropped++;
            end
        end
        else
        begin
            queries_sent++;
            pred = '0;
            pred.ovf = drop_flag;
            tie = 1'b0;
            best = 0;
            best_d = 0;
            for (int j = 0; j < n_stored; j++)
            begin
                dx = longint'(point_store_x[j]) - longint'(x);
                dy = longint'(point_store_y[j]) - longint'(y);
                d = dx * dx + dy * dy;
                // Strictly smaller wins, so the earliest point keeps a tie.
                if (j == 0 || d < best_d)
                begin
                    best_d = d;
                    best = j;
                end
                else if (d == best_d)
                begin
                    tie = 1'b1;
                end
            end
            if (n_stored != 0)
            begin
                pred.found = 1'b1;
                pred.x = point_store_x[best];
                pred.y = point_store_y[best];
                pred.index = IDX_BITS'(best);
                pred.dist_sq = DIST_BITS'(best_d);
            end
            if (tie)
                tie_queries++;
            if (typed)
                pred = want;
            pending_matches = {pending_matches, pred};
        end
        @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        match_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("result transaction with no query outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_matches.pop_front();
                results_checked++;
                check_field("found", want.found, found);
                check_field("match_x", want.x, match_x);
                check_field("match_y", want.y, match_y);
                check_field("match_index", want.index, match_index);
                check_field("min_sq_dist", want.dist_sq, min_sq_dist);
                check_field("set_overflowed", want.ovf, set_overflowed);
            end
        end
    end

    initial
    begin
        int n_pts;
        int n_q;
        int pick;
        int phase_start;
        int room;
        logic signed [COORD_BITS-1:0] qx;
        logic signed [COORD_BITS-1:0] qy;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            send_request(directed_rows[r].req, directed_rows[r].ns,
                         COORD_BITS'(directed_rows[r].x), COORD_BITS'(directed_rows[r].y),
                         directed_rows[r].typed, directed_rows[r].want);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                room = ITEMS_PER_PHASE - (items_sent - phase_start);
                if ($urandom_range(0, 9) == 0)
                    n_pts = $urandom_range(50, 300);
                else
                    n_pts = $urandom_range(1, 16);
                // A large set only fills what is left of the phase.
                if (n_pts > room)
                    n_pts = room;
                n_q = $urandom_range(1, 6);

                for (int k = 0; k < n_pts; k++)
                begin
                    if (k != 0 && $urandom_range(0, 6) == 0)
                    begin
                        pick = $urandom_range(0, n_stored - 1);
                        qx = point_store_x[pick];
                        qy = point_store_y[pick];
                    end
                    else
                    begin
                        qx = rand_coord();
                        qy = rand_coord();
                    end
                    send_request(REQ_LOAD, k == 0 || $urandom_range(0, 29) == 0,
                                 qx, qy, 1'b0, NO_MATCH);
                end

                for (int k = 0; k < n_q; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_request(REQ_LOAD, 1'b0, rand_coord(), rand_coord(), 1'b0,
                                     NO_MATCH);
                    aim_query(qx, qy);
                    send_request(REQ_QUERY, 1'($urandom_range(0, 1)), qx, qy, 1'b0,
                                 NO_MATCH);
                end
            end
        end

        in_valid = 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d loads (%0d dropped) and %0d queries over four stall phases.",
                 loads_sent, loads_dropped, queries_sent);
        $display("%0d results checked, %0d queries met a distance tie; %0d mismatches.",
                 results_checked, tie_queries, mismatches);
        if (mismatches == 0)
        begin
            $display("** nearest_point_match: PASSED **");
        end
        else
        begin
            $display("** nearest_point_match: FAILED **");
        end
        $finish;
    end

endmodule
